FILE: rtl/asob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asob_pkg
// Types, constants and the divider step shared by the source-over blender.
// ----------------------------------------------------------------------------
package asob_pkg;

    localparam int NumLanes = 3;
    localparam int NumW     = 17;
    localparam int QuoW     = 9;

    localparam logic [7:0]  ChMax   = 8'd255;
    localparam logic [15:0] ChHalf  = 16'd127;
    // floor(x/255) == (x * Recip16) >> 23 for x < 2^16
    localparam logic [15:0] Recip16 = 16'd32897;
    // floor(x/255) == (x * Recip24) >> 31 for x < 2^24
    localparam logic [23:0] Recip24 = 24'h808081;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
    } t_in_pix;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out_pix;

    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } t_div_ctl;

    // one restoring step: remainder stays below den
    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
                                            input logic [7:0] den);
        logic [8:0] trial;
        logic [8:0] diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            return {1'b1, diff[7:0]};
        end else begin
            return {1'b0, trial[7:0]};
        end
    endfunction

endpackage

FILE: rtl/asob_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asob_in_if
// Input channel: source and destination pixel pair.
// ----------------------------------------------------------------------------
interface asob_in_if;
    logic              valid;
    logic              ready;
    asob_pkg::t_in_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/asob_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asob_out_if
// Output channel: composited pixel.
// ----------------------------------------------------------------------------
interface asob_out_if;
    logic               valid;
    logic               ready;
    asob_pkg::t_out_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/alpha_source_over_blend_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_source_over_blend_core
// Source-over composite of a non-premultiplied RGBA8 source onto a
// destination pixel, one pixel pair per beat.
//
// i_in carries a source/destination pixel pair; o_out carries the blended
// pixel. Both are valid/ready channels; a beat moves when both are high.
// A pixel passes through all the stages listed below, one after another;
// o_out.valid comes from the stage 8 register. Throughput is one pixel per
// clock while the receiver accepts: every stage, including the three-stage
// divider that forms each color quotient, takes a new pixel each cycle.
// Stages: 1 products, 2 alpha reciprocal and dst weighting, 3 alpha sum and
// dst /255, 4 numerator sum, 5-7 color divide, 8 select and output register.
// Transparent and opaque sources bypass the arithmetic alongside the pipe.
// Reset clears all stage valid bits; no pixel is in flight afterward.
// When the receiver stalls, each full stage holds and upstream stages keep
// filling empty slots, so input is taken until the pipe is full.
// ----------------------------------------------------------------------------
module alpha_source_over_blend_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    asob_in_if.sink    i_in,
    asob_out_if.source o_out
);

    localparam int L = asob_pkg::NumLanes;

    logic [8:1] r_vld;
    logic [9:1] en;

    logic [7:0] s_ch [L];
    logic [7:0] d_ch [L];
    logic [7:0] sa, da, w;
    asob_pkg::t_out_pix n_byp;
    logic               n_bsel;

    asob_pkg::t_out_pix r_byp  [1:7];
    logic               r_bsel [1:7];

    logic [15:0] r1_sc [L];
    logic [15:0] r1_dd [L];
    logic [15:0] r1_daw;
    logic [7:0]  r1_sa, r1_w;

    logic [15:0] r2_sc  [L];
    logic [23:0] r2_ddw [L];
    logic [31:0] r2_oap;
    logic [7:0]  r2_sa;
    logic [15:0] oa_num;

    logic [15:0] r3_sc  [L];
    logic [47:0] r3_dcp [L];
    logic [7:0]  r3_oa;
    logic [8:0]  oa_sum;

    logic [asob_pkg::NumW-1:0] r4_num [L];
    logic [7:0]                r_oa   [4:7];

    logic [asob_pkg::QuoW-1:0] quo [L];
    asob_pkg::t_div_ctl        div_ctl;

    asob_pkg::t_out_pix r_out;
    asob_pkg::t_out_pix n_out;

    always_comb begin
        en[9] = o_out.ready;
        for (int k = 8; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[1];

    always_comb begin
        s_ch[0] = i_in.data.src_red;
        s_ch[1] = i_in.data.src_green;
        s_ch[2] = i_in.data.src_blue;
        d_ch[0] = i_in.data.dst_red;
        d_ch[1] = i_in.data.dst_green;
        d_ch[2] = i_in.data.dst_blue;
        sa      = i_in.data.src_alpha;
        da      = i_in.data.dst_alpha;
        w       = asob_pkg::ChMax - sa;
        n_bsel  = (sa == '0) || (sa == asob_pkg::ChMax);
        if (sa == '0) begin
            n_byp = {i_in.data.dst_red, i_in.data.dst_green,
                     i_in.data.dst_blue, i_in.data.dst_alpha};
        end else begin
            n_byp = {i_in.data.src_red, i_in.data.src_green,
                     i_in.data.src_blue, asob_pkg::ChMax};
        end
        oa_num = r1_daw + asob_pkg::ChHalf;
        oa_sum = {1'b0, r2_sa} + r2_oap[31:23];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= 8; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int c = 0; c < L; c++) begin
                r1_sc[c] <= {8'b0, s_ch[c]} * {8'b0, sa};
                r1_dd[c] <= {8'b0, d_ch[c]} * {8'b0, da};
            end
            r1_daw    <= {8'b0, da} * {8'b0, w};
            r1_sa     <= sa;
            r1_w      <= w;
            r_byp[1]  <= n_byp;
            r_bsel[1] <= n_bsel;
        end
        for (int k = 2; k <= 7; k++) begin
            if (en[k]) begin
                r_byp[k]  <= r_byp[k-1];
                r_bsel[k] <= r_bsel[k-1];
            end
        end
        if (en[2]) begin
            for (int c = 0; c < L; c++) begin
                r2_sc[c]  <= r1_sc[c];
                r2_ddw[c] <= {8'b0, r1_dd[c]} * {16'b0, r1_w};
            end
            r2_oap <= {16'b0, oa_num} * {16'b0, asob_pkg::Recip16};
            r2_sa  <= r1_sa;
        end
        if (en[3]) begin
            for (int c = 0; c < L; c++) begin
                r3_sc[c]  <= r2_sc[c];
                r3_dcp[c] <= {24'b0, r2_ddw[c]} * {24'b0, asob_pkg::Recip24};
            end
            r3_oa <= oa_sum[7:0];
        end
        if (en[4]) begin
            for (int c = 0; c < L; c++) begin
                r4_num[c] <= {1'b0, r3_sc[c]} + r3_dcp[c][47:31];
            end
            r_oa[4] <= r3_oa;
        end
        for (int k = 5; k <= 7; k++) begin
            if (en[k]) begin
                r_oa[k] <= r_oa[k-1];
            end
        end
        if (en[8]) begin
            r_out <= n_out;
        end
    end

    assign div_ctl = '{en_a: en[5], en_b: en[6], en_c: en[7]};

    for (genvar c = 0; c < L; c++) begin : g_lane
        asob_div u_div (
            .i_clk (i_clk),
            .i_ctl (div_ctl),
            .i_num (r4_num[c]),
            .i_den (r_oa[4]),
            .o_quo (quo[c])
        );
    end

    function automatic logic [7:0] sat8(input logic [asob_pkg::QuoW-1:0] q);
        return q[8] ? asob_pkg::ChMax : q[7:0];
    endfunction

    always_comb begin
        if (r_bsel[7]) begin
            n_out = r_byp[7];
        end else begin
            n_out = {sat8(quo[0]), sat8(quo[1]), sat8(quo[2]), r_oa[7]};
        end
    end

    assign o_out.valid = r_vld[8];
    assign o_out.data  = r_out;

    // blended path always has a nonzero alpha divisor
    a_oa_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !r_bsel[4]) |-> (r_oa[4] != 8'd0))
        else $error("zero alpha divisor on blended path");

    // alpha rounding adds at most 127/out_alpha above full scale
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[7] && !r_bsel[7]) |->
        ((quo[0] <= 9'd382) && (quo[1] <= 9'd382) && (quo[2] <= 9'd382)))
        else $error("color quotient out of range");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[8] |-> i_in.ready)
        else $error("input stalled with empty output stage");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[1])
        else $error("accepted beat lost at first stage");

endmodule

FILE: rtl/asob_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asob_div
// Three-stage restoring divider, 17-bit numerator by 8-bit divisor, 9-bit
// quotient, three quotient bits per stage. Numerator must be below 512*den.
// ----------------------------------------------------------------------------
module asob_div (
    input  logic                         i_clk,
    input  asob_pkg::t_div_ctl           i_ctl,
    input  logic [asob_pkg::NumW-1:0]    i_num,
    input  logic [7:0]                   i_den,
    output logic [asob_pkg::QuoW-1:0]    o_quo
);

    logic [7:0] r_rem_a, r_rem_b;
    logic [2:0] r_q_a;
    logic [5:0] r_q_b;
    logic [8:0] r_q_c;
    logic [5:0] r_low_a;
    logic [2:0] r_low_b;
    logic [7:0] r_den_a, r_den_b;

    logic [7:0] n_rem_a, n_rem_b, n_rem_c;
    logic [2:0] n_q_a, n_q_b, n_q_c;
    logic [8:0] step_a, step_b, step_c;

    always_comb begin
        n_rem_a = i_num[16:9];
        n_q_a   = '0;
        step_a  = '0;
        for (int k = 0; k < 3; k++) begin
            step_a       = asob_pkg::div_step(n_rem_a, i_num[8-k], i_den);
            n_q_a[2-k]   = step_a[8];
            n_rem_a      = step_a[7:0];
        end
    end

    always_comb begin
        n_rem_b = r_rem_a;
        n_q_b   = '0;
        step_b  = '0;
        for (int k = 0; k < 3; k++) begin
            step_b       = asob_pkg::div_step(n_rem_b, r_low_a[5-k], r_den_a);
            n_q_b[2-k]   = step_b[8];
            n_rem_b      = step_b[7:0];
        end
    end

    always_comb begin
        n_rem_c = r_rem_b;
        n_q_c   = '0;
        step_c  = '0;
        for (int k = 0; k < 3; k++) begin
            step_c       = asob_pkg::div_step(n_rem_c, r_low_b[2-k], r_den_b);
            n_q_c[2-k]   = step_c[8];
            n_rem_c      = step_c[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_rem_a <= n_rem_a;
            r_q_a   <= n_q_a;
            r_low_a <= i_num[5:0];
            r_den_a <= i_den;
        end
        if (i_ctl.en_b) begin
            r_rem_b <= n_rem_b;
            r_q_b   <= {r_q_a, n_q_b};
            r_low_b <= r_low_a[2:0];
            r_den_b <= r_den_a;
        end
        if (i_ctl.en_c) begin
            r_q_c   <= {r_q_b, n_q_c};
        end
    end

    assign o_quo = r_q_c;

endmodule
